FILE: rtl/smsa_pkg.sv
package smsa_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int CELL_IDX_W = $clog2(WINDOW_MAX);
   localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = SAMPLE_W + 1;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_LEN_W  = 7;

   // Register index codes (byte address divided by four).
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_DAYS = 1'b0;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // Broadcast to every cell of the sorted chain.
   typedef struct packed {
      logic       load;
      logic       clear;
      logic       start;
      logic       remove;
      sample_type sample;
      sample_type oldest;
   } cell_ctrl_type;

   // Handed from a cell to the cell below it.
   typedef struct packed {
      logic       gt_oldest;
      logic       valid;
      sample_type value;
   } cell_down_type;

   // Handed from a cell to the cell above it: its entry after removal.
   typedef struct packed {
      logic       big;
      logic       valid;
      sample_type value;
   } cell_up_type;

endpackage

FILE: rtl/smsa_ifs.sv
interface smsa_req_if
   import smsa_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       start_of_series;

   modport source (output valid, output sample, output start_of_series, input ready);
   modport sink   (input valid, input sample, input start_of_series, output ready);
endinterface

interface smsa_rsp_if
   import smsa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               alert;
   logic               window_full;
   logic [COUNT_W-1:0] alert_count;

   modport source (output valid, output alert, output window_full, output alert_count,
                   input ready);
   modport sink   (input valid, input alert, input window_full, input alert_count,
                   output ready);
endinterface

FILE: rtl/smsa_sort_cell.sv
module smsa_sort_cell
   import smsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_down_type from_above,
   output cell_down_type to_below,
   input  cell_up_type   from_below,
   output cell_up_type   to_above,
   output sample_type    value,
   output logic          valid
);

   sample_type value_ff, value_in;
   logic       valid_ff, valid_in;
   logic       cur_valid;
   logic       shift_down;
   sample_type w_value;
   logic       w_valid;
   logic       big;

   // A start of series empties the window before the sample is taken.
   assign cur_valid = valid_ff && !ctrl.start;

   assign to_below.gt_oldest = !cur_valid || (value_ff > ctrl.oldest);
   assign to_below.valid     = cur_valid;
   assign to_below.value     = value_ff;

   // Every cell from the removed entry upwards takes its upper neighbour's entry.
   assign shift_down = ctrl.remove && from_above.gt_oldest;
   assign w_value    = shift_down ? from_above.value : value_ff;
   assign w_valid    = shift_down ? from_above.valid : cur_valid;
   assign big        = !w_valid || (w_value > ctrl.sample);

   assign to_above.big   = big;
   assign to_above.valid = w_valid;
   assign to_above.value = w_value;

   always_comb begin
      priority if (from_below.big) begin
         value_in = from_below.value;
         valid_in = from_below.valid;
      end else if (big) begin
         value_in = ctrl.sample;
         valid_in = 1'b1;
      end else begin
         value_in = w_value;
         valid_in = w_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

FILE: rtl/smsa_sort_chain.sv
module smsa_sort_chain
   import smsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [CELL_IDX_W-1:0] lo_idx,
   input  logic [CELL_IDX_W-1:0] hi_idx,
   output logic [SUM_W-1:0]      median_sum,
   output logic [WINDOW_MAX-1:0] valid_vec
);

   cell_down_type down [WINDOW_MAX+1];
   cell_up_type   up   [WINDOW_MAX+1];
   sample_type    values [WINDOW_MAX];
   sample_type    lo_term [WINDOW_MAX];
   sample_type    hi_term [WINDOW_MAX];
   sample_type    lo_val, hi_val;

   // Above the top cell sits an empty entry; below cell zero nothing is bigger.
   assign down[WINDOW_MAX] = '{gt_oldest: 1'b1, valid: 1'b0, value: '0};
   assign up[0]            = '{big: 1'b0, valid: 1'b0, value: '0};

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      smsa_sort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .from_above (down[i+1]),
         .to_below   (down[i]),
         .from_below (up[i]),
         .to_above   (up[i+1]),
         .value      (values[i]),
         .valid      (valid_vec[i])
      );
      assign lo_term[i] = values[i] & {SAMPLE_W{lo_idx == CELL_IDX_W'(i)}};
      assign hi_term[i] = values[i] & {SAMPLE_W{hi_idx == CELL_IDX_W'(i)}};
   end

   always_comb begin
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         lo_val = lo_val | lo_term[i];
         hi_val = hi_val | hi_term[i];
      end
   end

   assign median_sum = {1'b0, lo_val} + {1'b0, hi_val};

endmodule

FILE: rtl/smsa_hist_line.sv
module smsa_hist_line
   import smsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  load,
   input  sample_type            sample_in,
   input  logic [CELL_IDX_W-1:0] tap_idx,
   output sample_type            oldest
);

   sample_type hist_ff [WINDOW_MAX];
   sample_type tap_term [WINDOW_MAX];

   // Entry k holds the sample taken k transactions ago.
   always_ff @(posedge clock) begin
      if (load) begin
         hist_ff[0] <= sample_in;
         for (int k = 1; k < WINDOW_MAX; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_tap
      assign tap_term[k] = hist_ff[k] & {SAMPLE_W{tap_idx == CELL_IDX_W'(k)}};
   end

   always_comb begin
      oldest = '0;
      for (int k = 0; k < WINDOW_MAX; k++) begin
         oldest = oldest | tap_term[k];
      end
   end

endmodule

FILE: rtl/sliding_median_spike_alert_top.sv
// Channel   Direction  Handshake       Payload
// req_ch    in         valid / ready   sample[15:0], start_of_series
// rsp_ch    out        valid / ready   alert, window_full, alert_count[31:0]
// csr_*     in/out     APB write/read  window_days[6:0] at byte address 0
//
// One transaction is taken per clock cycle while req_ch.ready is high: the sorted chain of
// 64 cells removes the oldest sample once the window is full and inserts the new one in the
// same cycle, and the result appears in the output register on the next cycle.
// Reset is synchronous and empties the window; window_days returns to 1.
// req_ch.ready stays high while the output register is empty or being taken, so a
// stalled result holds back only the following transaction.
module sliding_median_spike_alert_top
   import smsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   smsa_req_if.sink              req_ch,
   smsa_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_LEN_W-1:0]  window_days_ff;
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic [COUNT_W-1:0]    alerts_ff, alerts_in, alerts_base;
   logic                  rsp_valid_ff;
   logic                  rsp_alert_ff, rsp_full_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic                  csr_write;
   logic                  cfg_hit;
   logic [CSR_ADDR_W-3:0] csr_index;
   logic [LEN_W-1:0]      d_eff, d_less_one;
   logic [CELL_IDX_W-1:0] lo_idx, hi_idx;
   logic [SUM_W-1:0]      median_sum;
   logic [WINDOW_MAX-1:0] valid_vec;
   sample_type            oldest;
   logic                  accept, start, full, alert;
   cell_ctrl_type         ctrl;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_hit    = csr_write && (csr_index == REG_WINDOW_DAYS);

   always_comb begin
      if (csr_index == REG_WINDOW_DAYS) begin
         csr_prdata = {{(CSR_DATA_W-CFG_LEN_W){1'b0}}, window_days_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_days_ff <= CFG_LEN_W'(1);
      end else if (cfg_hit) begin
         window_days_ff <= csr_pwdata[CFG_LEN_W-1:0];
      end
   end

   // A length of zero acts as one; lengths above the chain act as the whole chain.
   always_comb begin
      priority if (window_days_ff == '0) begin
         d_eff = LEN_W'(1);
      end else if (window_days_ff > CFG_LEN_W'(WINDOW_MAX)) begin
         d_eff = LEN_W'(WINDOW_MAX);
      end else begin
         d_eff = LEN_W'(window_days_ff);
      end
   end

   assign d_less_one = d_eff - LEN_W'(1);
   assign hi_idx     = d_eff[CELL_IDX_W:1];
   assign lo_idx     = d_eff[0] ? hi_idx : hi_idx - CELL_IDX_W'(1);

   // Input side.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign start        = accept && req_ch.start_of_series;
   assign full         = accept && !req_ch.start_of_series && (fill_ff >= d_eff);
   assign alert        = full && ({1'b0, req_ch.sample} >= median_sum);

   assign ctrl.load   = accept;
   assign ctrl.clear  = cfg_hit;
   assign ctrl.start  = start;
   assign ctrl.remove = full;
   assign ctrl.sample = req_ch.sample;
   assign ctrl.oldest = oldest;

   smsa_hist_line u_hist (
      .clock     (clock),
      .load      (accept),
      .sample_in (req_ch.sample),
      .tap_idx   (d_less_one[CELL_IDX_W-1:0]),
      .oldest    (oldest)
   );

   smsa_sort_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .lo_idx     (lo_idx),
      .hi_idx     (hi_idx),
      .median_sum (median_sum),
      .valid_vec  (valid_vec)
   );

   // Fill level and saturating alert count.
   assign alerts_base = start ? '0 : alerts_ff;
   assign alerts_in   = (alert && (alerts_base != '1)) ? alerts_base + COUNT_W'(1)
                                                       : alerts_base;

   always_comb begin
      priority if (cfg_hit) begin
         fill_in = '0;
      end else if (!accept) begin
         fill_in = fill_ff;
      end else if (start) begin
         fill_in = LEN_W'(1);
      end else if (full) begin
         fill_in = d_eff;
      end else begin
         fill_in = fill_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         alerts_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (accept) begin
            alerts_ff <= alerts_in;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_alert_ff <= alert;
         rsp_full_ff  <= full;
         rsp_count_ff <= alerts_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.alert       = rsp_alert_ff;
   assign rsp_ch.window_full = rsp_full_ff;
   assign rsp_ch.alert_count = rsp_count_ff;

   // The chain holds exactly as many live entries as the fill level says.
   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("sorted chain occupancy differs from fill level");

   a_fill_within_len: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= d_eff)
      else $error("fill level exceeds window length");

   a_alert_needs_full: assert property (@(posedge clock) disable iff (reset)
      accept && alert |=> rsp_valid_ff && rsp_full_ff && (rsp_count_ff != '0))
      else $error("alert reported without a full window or a count");

endmodule

FILE: tb/tb_top.sv
module tb_top
   import smsa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] WINDOW_DAYS_ADDR = {REG_WINDOW_DAYS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR    = {~REG_WINDOW_DAYS, 2'b00};

   localparam int          SCRIPT_LEN        = 26;
   localparam int          NUM_PHASES        = 12;
   localparam int          PHASE_ITEMS       = 110;
   localparam int          SETTLE_CYCLES     = 4;
   localparam int          DRAIN_CYCLES      = 20;
   localparam int          LONG_STALL_CYCLES = 400;
   localparam int unsigned TIMEOUT_NS        = 5_000_000;

   typedef struct packed {
      logic               alert;
      logic               window_full;
      logic [COUNT_W-1:0] alert_count;
   } verdict_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
      sample_type            sample;
      logic                  start;
      logic                  pinned;
      verdict_type           want;
   } script_row_type;

   localparam verdict_type NO_VERDICT = '0;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Travel alongside the request payload so the monitor sees a consistent pair.
   logic                  req_pinned;
   verdict_type           req_pinned_verdict;

   logic                  rx_hold_armed;
   logic                  rx_hold_done;

   smsa_req_if req_ch ();
   smsa_rsp_if rsp_ch ();

   sliding_median_spike_alert_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the detector state.
   logic [CFG_LEN_W-1:0] win_len_reg;
   sample_type           arrival_ring [WINDOW_MAX];
   sample_type           ordered_win  [WINDOW_MAX];
   int unsigned          held_count;
   int unsigned          ring_head;
   logic [COUNT_W-1:0]   series_alerts;

   verdict_type pending_verdicts [$];
   int unsigned mismatches;
   int unsigned results_seen;

   script_row_type script [SCRIPT_LEN] = '{
      '{ROW_ITEM, '0, '0, 16'd100,   1'b1, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{ROW_ITEM, '0, '0, 16'd200,   1'b0, 1'b1, '{1'b1, 1'b1, 32'd1}},
      '{ROW_ITEM, '0, '0, 16'd399,   1'b0, 1'b1, '{1'b0, 1'b1, 32'd1}},
      '{ROW_ITEM, '0, '0, 16'd65535, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd2}},
      '{ROW_ITEM, '0, '0, 16'd0,     1'b0, 1'b1, '{1'b0, 1'b1, 32'd2}},
      '{ROW_ITEM, '0, '0, 16'd0,     1'b0, 1'b1, '{1'b1, 1'b1, 32'd3}},
      '{ROW_CSR, WINDOW_DAYS_ADDR, 32'd0, '0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd5,     1'b0, 1'b1, '{1'b0, 1'b0, 32'd3}},
      '{ROW_ITEM, '0, '0, 16'd10,    1'b0, 1'b1, '{1'b1, 1'b1, 32'd4}},
      '{ROW_CSR, UNMAPPED_ADDR, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd20,    1'b0, 1'b1, '{1'b1, 1'b1, 32'd5}},
      '{ROW_CSR, WINDOW_DAYS_ADDR, 32'd2, '0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd10,    1'b0, 1'b1, '{1'b0, 1'b0, 32'd5}},
      '{ROW_ITEM, '0, '0, 16'd30,    1'b0, 1'b1, '{1'b0, 1'b0, 32'd5}},
      '{ROW_ITEM, '0, '0, 16'd40,    1'b0, 1'b1, '{1'b1, 1'b1, 32'd6}},
      '{ROW_ITEM, '0, '0, 16'd69,    1'b0, 1'b1, '{1'b0, 1'b1, 32'd6}},
      '{ROW_ITEM, '0, '0, 16'd7,     1'b1, 1'b1, '{1'b0, 1'b0, 32'd0}},
      '{ROW_CSR, WINDOW_DAYS_ADDR, 32'hFFFF_FF83, '0, 1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd5,     1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd1,     1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd9,     1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd10,    1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd9,     1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd9,     1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd9,     1'b0, 1'b0, NO_VERDICT},
      '{ROW_ITEM, '0, '0, 16'd18,    1'b0, 1'b0, NO_VERDICT}
   };

   logic [CFG_LEN_W-1:0] phase_len [NUM_PHASES] = '{
      7'd1, 7'd64, 7'd0, 7'd2, 7'd127, 7'd3, 7'd65, 7'd9, 7'd64, 7'd16, 7'd100, 7'd33
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch at result %0d: %s", results_seen, msg);
   endtask

   function automatic void ordered_insert(int unsigned n, sample_type v);
      int unsigned i;
      if (n >= WINDOW_MAX) return;
      i = n;
      while (i > 0 && ordered_win[i-1] > v) begin
         ordered_win[i] = ordered_win[i-1];
         i--;
      end
      ordered_win[i] = v;
   endfunction

   // Works out the verdict for one sample and moves the window on.
   function automatic verdict_type judge_sample(sample_type s, logic sos);
      int unsigned d;
      int unsigned lo_mid;
      int unsigned hi_mid;
      int unsigned twice;
      int unsigned slot;
      bit          found;
      verdict_type v;
      d = 32'(win_len_reg);
      if (d == 0) d = 1;
      if (d > WINDOW_MAX) d = WINDOW_MAX;
      if (sos) begin
         held_count    = 0;
         ring_head     = 0;
         series_alerts = '0;
      end
      v = '0;
      v.window_full = (held_count >= d);
      if (v.window_full) begin
         hi_mid = 32'(ordered_win[d/2]);
         lo_mid = (d % 2 == 1) ? hi_mid : 32'(ordered_win[d/2 - 1]);
         twice  = lo_mid + hi_mid;
         if (32'(s) >= twice) begin
            v.alert = 1'b1;
            if (series_alerts != '1) series_alerts++;
         end
         ring_head = ring_head % d;
         // Only one copy of the departing value leaves, even when duplicates sit alongside.
         found = 1'b0;
         for (int i = 0; i < d; i++) begin
            if (!found && ordered_win[i] == arrival_ring[ring_head]) found = 1'b1;
            if (found && i + 1 < d) ordered_win[i] = ordered_win[i+1];
         end
         ordered_insert(d - 1, s);
         arrival_ring[ring_head] = s;
         ring_head  = (ring_head + 1) % d;
         held_count = d;
      end else begin
         slot = (ring_head + held_count) % d;
         ordered_insert(held_count, s);
         arrival_ring[slot] = s;
         held_count++;
      end
      v.alert_count = series_alerts;
      return v;
   endfunction

   always @(posedge clock) begin : check_results
      verdict_type want;
      verdict_type predicted;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
               report_mismatch("result transaction with nothing pending");
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_ch.alert !== want.alert)
                  report_mismatch($sformatf("alert got %0b expected %0b",
                                            rsp_ch.alert, want.alert));
               if (rsp_ch.window_full !== want.window_full)
                  report_mismatch($sformatf("window_full got %0b expected %0b",
                                            rsp_ch.window_full, want.window_full));
               if (rsp_ch.alert_count !== want.alert_count)
                  report_mismatch($sformatf("alert_count got %0d expected %0d",
                                            rsp_ch.alert_count, want.alert_count));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predicted = judge_sample(req_ch.sample, req_ch.start_of_series);
            pending_verdicts.insert(pending_verdicts.size(),
                                    req_pinned ? req_pinned_verdict : predicted);
         end
      end
   end

   // The receiver wanders between stall patterns and, once, holds off for a long stretch.
   initial begin : receiver
      rx_mode_type mode;
      int unsigned tick;
      logic        rdy;
      mode = RX_ALWAYS;
      tick = 0;
      rx_hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold_armed && !rx_hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
            rx_hold_done = 1'b1;
         end
         tick++;
         if (tick % 97 == 0) mode = rx_mode_type'($urandom_range(0, 3));
         case (mode)
            RX_ALWAYS:   rdy = 1'b1;
            RX_COIN:     rdy = 1'($urandom_range(0, 1));
            RX_PERIODIC: rdy = (tick % 5) != 0;
            default:     rdy = ($urandom_range(0, 7) == 0);
         endcase
         rsp_ch.ready <= rdy;
      end
   end

   task automatic send_item(sample_type s, logic sos, logic pin, verdict_type pin_v,
                            int unsigned gap);
      req_ch.valid           <= 1'b1;
      req_ch.sample          <= s;
      req_ch.start_of_series <= sos;
      req_pinned             <= pin;
      req_pinned_verdict     <= pin_v;
      do @(posedge clock); while (!req_ch.ready);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lets every outstanding transaction drain before the window length is touched.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[CSR_ADDR_W-1:2] == REG_WINDOW_DAYS) begin
         win_len_reg = data[CFG_LEN_W-1:0];
         held_count  = 0;
         ring_head   = 0;
      end
      @(posedge clock);
      // The address is still on the bus, so the read data shows the register just written.
      if (addr[CSR_ADDR_W-1:2] == REG_WINDOW_DAYS) begin
         if (csr_prdata !== CSR_DATA_W'(win_len_reg))
            report_mismatch($sformatf("window_days read back %0d expected %0d",
                                      csr_prdata, win_len_reg));
      end else if (csr_prdata !== '0) begin
         report_mismatch($sformatf("unmapped register read back %0h", csr_prdata));
      end
   endtask

   function automatic int unsigned pick_base();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 0;
      if (pick < 10) return $urandom_range(1, 200);
      if (pick < 18) return $urandom_range(201, 20000);
      return $urandom_range(20001, 65535);
   endfunction

   // Mostly readings around a series level, with plateaus, doublings (exact or one below) and spikes.
   function automatic sample_type spend_sample(int unsigned base);
      int unsigned pick;
      int unsigned jitter;
      int unsigned lo;
      int unsigned v;
      pick   = $urandom_range(0, 99);
      jitter = base / 8 + 2;
      if (pick < 55) begin
         lo = (base > jitter) ? base - jitter : 0;
         v  = $urandom_range(lo, base + jitter);
      end else if (pick < 72) begin
         v = base;
      end else if (pick < 80) begin
         v = 2 * base;
         if (v != 0 && $urandom_range(0, 1) == 1) v--;
      end else if (pick < 92) begin
         v = 2 * base + $urandom_range(0, 3 * base + 64);
      end else begin
         v = $urandom_range(0, 65535);
      end
      if (v > 65535) v = 65535;
      return sample_type'(v);
   endfunction

   initial begin : stimulus
      int unsigned          burst_left;
      int unsigned          gap;
      int unsigned          base;
      logic                 sos;
      logic [CFG_LEN_W-1:0] len;
      logic [CSR_DATA_W-1:0] noise;
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.sample          <= '0;
      req_ch.start_of_series <= 1'b0;
      req_pinned             <= 1'b0;
      req_pinned_verdict     <= '0;
      rx_hold_armed          <= 1'b0;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      win_len_reg   = CFG_LEN_W'(1);
      held_count    = 0;
      ring_head     = 0;
      series_alerts = '0;
      mismatches    = 0;
      results_seen  = 0;
      burst_left    = 0;
      base          = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].kind == ROW_CSR) begin
            settle();
            csr_write(script[r].addr, script[r].data);
         end else begin
            send_item(script[r].sample, script[r].start, script[r].pinned, script[r].want,
                      $urandom_range(0, 2));
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         len   = (phase == 7 || phase == 9) ? CFG_LEN_W'($urandom_range(4, 63))
                                            : phase_len[phase];
         noise = $urandom;
         csr_write(WINDOW_DAYS_ADDR, {noise[CSR_DATA_W-1:CFG_LEN_W], len});
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Mid-phase write to an unmapped register: the window must survive it.
            if (phase % 3 == 2 && k == PHASE_ITEMS / 2) begin
               settle();
               csr_write(UNMAPPED_ADDR, $urandom);
            end
            if (phase == 1 && k == 10) begin
               rx_hold_armed <= 1'b1;
               burst_left = 300;
            end
            if (k == 0 || $urandom_range(0, 69) == 0) begin
               base = pick_base();
               sos  = 1'b1;
            end else begin
               sos  = 1'b0;
            end
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 24);
            end
            burst_left--;
            gap = (burst_left == 0) ? $urandom_range(1, 10) : 0;
            send_item(spend_sample(base), sos, 1'b0, NO_VERDICT, gap);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
